// File: design/bcsm_pkg.sv
// shared types and constants for the banked cartridge sram mapper
package bcsm_pkg;

  localparam int unsigned BANK_COUNT_DEF = 32;
  localparam int unsigned BANK_W = 5;
  localparam int unsigned FLAG_W = 6;
  localparam int unsigned LOC_W = 19;
  localparam int unsigned OFS_W = 14;

  // register offsets inside the I/O page, address bits 1:0
  localparam logic [1:0] REG_BANK = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  // control flag bit positions
  localparam int unsigned F_MAX = 0;
  localparam int unsigned F_IODIS = 1;
  localparam int unsigned F_SRAMWE = 2;
  localparam int unsigned F_SRAMSEL = 3;
  localparam int unsigned F_GAME = 4;
  localparam int unsigned F_EXROM = 5;

  typedef enum logic [1:0] {
    SRC_OPEN = 2'd0,
    SRC_REG  = 2'd1,
    SRC_SRAM = 2'd2
  } src_t;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } act_t;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]       register_data;
    src_t             data_source;
    logic [LOC_W-1:0] sram_location;
    logic             sram_store;
    logic [7:0]       sram_store_byte;
    logic             rom_reload;
    logic [BANK_W-1:0] rom_bank;
    logic             game_line;
    logic             exrom_line;
    logic             bus_driven;
    logic             rom_claimed;
    logic             write_to_cart;
  } rsp_t;

endpackage

// File: design/bcsm_if.sv
// valid/ready channels for bus accesses and decode results
interface bcsm_req_if;
  import bcsm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcsm_rsp_if;
  import bcsm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/banked_cartridge_sram_mapper_top.sv
// cartridge mapper: bank/control registers and per-access sram decode
// Each CPU bus access on req is decoded combinationally and its result appears on rsp
// the cycle after it is accepted; a new access is taken every cycle as long as
// the result register is empty or is being drained, so the sustained rate is one
// access per clock through the single result register. The bank and control
// registers update at the edge where their write is accepted, and the claim and
// line outputs of a result reflect that update.
// BANK_COUNT folds the bank register into the populated SRAM banks (modulo).
module banked_cartridge_sram_mapper_top #(
  parameter int unsigned BANK_COUNT = bcsm_pkg::BANK_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  bcsm_req_if.sink       req,
  bcsm_rsp_if.source     rsp
);
  import bcsm_pkg::*;

  logic [BANK_W-1:0] bank_number;
  logic [BANK_W-1:0] bank_number_next;
  logic [FLAG_W-1:0] control_flags;
  logic [FLAG_W-1:0] control_flags_next;
  logic              rsp_valid;
  rsp_t              rsp_data;
  rsp_t              result;
  logic              accept;

  // bank folded into the populated range, worked out at elaboration
  logic [BANK_W-1:0] bank_fold [2**BANK_W];
  for (genvar i = 0; i < 2**BANK_W; i++) begin : g_fold
    localparam logic [BANK_W-1:0] FOLD = BANK_W'(i % BANK_COUNT);
    assign bank_fold[i] = FOLD;
  end

  logic [15:0]       a;
  logic [7:0]        v;
  logic              regs_visible;
  logic              hit_bank;
  logic              hit_ctrl;
  logic [BANK_W-1:0] base_bank;
  logic [OFS_W-1:0]  low_ofs;
  logic [OFS_W-1:0]  high_ofs;
  logic [OFS_W-1:0]  io_ofs;
  logic              in_low;
  logic              in_high_rd;
  logic              in_io;
  logic              in_df;
  logic              we;
  logic              ssel;
  logic              claim;
  logic              g_next;
  logic              e_next;

  assign accept = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;

  assign a = req.data.bus_address;
  assign v = req.data.write_byte;
  assign regs_visible = !control_flags[F_IODIS] && (a[15:8] == 8'hDE);
  assign hit_bank = regs_visible && (a[1:0] == REG_BANK);
  assign hit_ctrl = regs_visible && (a[1:0] == REG_CTRL);
  assign base_bank = bank_fold[bank_number];
  assign low_ofs = {1'b0, a[12:0]};
  assign high_ofs = {1'b1, a[12:0]};
  assign io_ofs = {5'b11111, a[8:0]};
  assign in_low = (a[15:13] == 3'b100);
  assign in_high_rd = (a[15:13] == 3'b101) || (a[15:13] == 3'b111);
  assign in_io = (a[15:9] == 7'b1101111);
  assign in_df = (a[15:8] == 8'hDF);
  assign we = control_flags[F_SRAMWE];
  assign ssel = control_flags[F_SRAMSEL];

  always_comb begin
    bank_number_next = bank_number;
    control_flags_next = control_flags;
    if (accept && req.data.action == ACT_WRITE) begin
      if (hit_bank) begin
        bank_number_next = v[BANK_W-1:0];
      end else if (hit_ctrl) begin
        control_flags_next = v[7:2];
      end
    end
  end

  // rom replacement for the mode after this access
  assign g_next = control_flags_next[F_GAME];
  assign e_next = control_flags_next[F_EXROM];
  always_comb begin
    claim = 1'b0;
    if (control_flags_next[F_SRAMSEL]) begin
      if (!g_next && !e_next) begin
        claim = (a[15:14] == 2'b10);
      end else if (g_next && !e_next) begin
        claim = in_low;
      end else if (!g_next && e_next) begin
        claim = in_low || (a[15:13] == 3'b111);
      end
    end
  end

  always_comb begin
    result = '0;
    result.data_source = SRC_OPEN;
    if (req.data.action == ACT_READ) begin
      if (hit_bank) begin
        result.register_data = {3'b000, bank_number};
        result.data_source = SRC_REG;
      end else if (hit_ctrl) begin
        result.register_data = {control_flags, 2'b00};
        result.data_source = SRC_REG;
      end else if (ssel && in_low) begin
        result.sram_location = {base_bank, low_ofs};
        result.data_source = SRC_SRAM;
      end else if (ssel && in_high_rd) begin
        result.sram_location = {base_bank, high_ofs};
        result.data_source = SRC_SRAM;
      end else if (in_io) begin
        result.sram_location = {base_bank, io_ofs};
        result.data_source = SRC_SRAM;
      end
    end else begin
      if (hit_bank) begin
        result.rom_reload = 1'b1;
      end else if (!hit_ctrl) begin
        if (we && !ssel && (in_df || (control_flags[F_IODIS] && a[15:8] == 8'hDE))) begin
          result.sram_location = {base_bank, io_ofs};
          result.sram_store = 1'b1;
        end else if (we && (a[15:13] == 3'b010 || in_low)) begin
          result.sram_location = {base_bank, low_ofs};
          result.sram_store = 1'b1;
        end else if (we && (a[15:13] == 3'b011 || a[15:13] == 3'b101)) begin
          result.sram_location = {base_bank, high_ofs};
          result.sram_store = 1'b1;
        end
        if (result.sram_store) begin
          result.sram_store_byte = v;
        end
      end
    end
    result.rom_bank = bank_number_next;
    result.game_line = g_next;
    result.exrom_line = e_next;
    result.bus_driven = in_io || claim;
    result.rom_claimed = claim;
    result.write_to_cart = control_flags_next[F_SRAMWE] &&
                           (a[15:14] == 2'b01 || a[15:14] == 2'b10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_number <= '0;
      control_flags <= '0;
      rsp_valid <= 1'b0;
    end else begin
      bank_number <= bank_number_next;
      control_flags <= control_flags_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

endmodule

// File: test/tb.sv
// testbench for the banked cartridge sram mapper: bus access stimulus and decode checking
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcsm_pkg::*;

  localparam int unsigned BANKS = BANK_COUNT_DEF;

  localparam logic [15:0] ADDR_EDGES [18] = '{
    16'h0000, 16'h3FFF, 16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF,
    16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hDDFF,
    16'hDE00, 16'hDEFF, 16'hDF00, 16'hDFFF, 16'hE000, 16'hFFFF
  };

  logic clk;
  logic rst;

  bcsm_req_if access_ch ();
  bcsm_rsp_if decode_ch ();

  banked_cartridge_sram_mapper_top #(.BANK_COUNT(BANKS)) dut (
    .clk (clk),
    .rst (rst),
    .req (access_ch),
    .rsp (decode_ch)
  );

  // mapper state as seen by the predictor
  logic [BANK_W-1:0] model_bank;
  logic [FLAG_W-1:0] model_flags;

  req_t pending_accesses[$];
  rsp_t awaited_decodes[$];
  int   mismatch_count;
  int   send_gap;
  int   stall_left;
  bit   send_calm;
  bit   recv_calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit in_span(logic [15:0] a, logic [15:0] lo, logic [15:0] hi);
    return a >= lo && a <= hi;
  endfunction

  // decode one access against the mapper state, updating it on register writes
  function automatic rsp_t decode_access(req_t a);
    rsp_t        r;
    logic [15:0] ad;
    logic [18:0] base;
    logic        regs_on;
    logic        we;
    logic        ssel;
    logic        g;
    logic        e;
    logic        claim;
    ad = a.bus_address;
    r = '0;
    r.data_source = SRC_OPEN;
    base = 19'((model_bank % BANKS) * 32'h4000);
    regs_on = !model_flags[F_IODIS] && in_span(ad, 16'hDE00, 16'hDEFF);
    ssel = model_flags[F_SRAMSEL];
    we = model_flags[F_SRAMWE];
    if (a.action == ACT_READ) begin
      if (regs_on && ad[1:0] == REG_BANK) begin
        r.register_data = 8'(model_bank);
        r.data_source = SRC_REG;
      end else if (regs_on && ad[1:0] == REG_CTRL) begin
        r.register_data = {model_flags, 2'b00};
        r.data_source = SRC_REG;
      end else if (ssel && in_span(ad, 16'h8000, 16'h9FFF)) begin
        r.sram_location = base + 19'(ad[12:0]);
        r.data_source = SRC_SRAM;
      end else if (ssel && (in_span(ad, 16'hA000, 16'hBFFF) || in_span(ad, 16'hE000, 16'hFFFF)))
      begin
        r.sram_location = base + 19'h02000 + 19'(ad[12:0]);
        r.data_source = SRC_SRAM;
      end else if (in_span(ad, 16'hDE00, 16'hDFFF)) begin
        r.sram_location = base + 19'h03E00 + 19'(ad[8:0]);
        r.data_source = SRC_SRAM;
      end
    end else begin
      if (regs_on && ad[1:0] == REG_BANK) begin
        model_bank = a.write_byte[4:0];
        r.rom_reload = 1'b1;
      end else if (regs_on && ad[1:0] == REG_CTRL) begin
        model_flags = a.write_byte[7:2];
      end else begin
        if (we && !ssel && (in_span(ad, 16'hDF00, 16'hDFFF) ||
            (model_flags[F_IODIS] && in_span(ad, 16'hDE00, 16'hDEFF)))) begin
          r.sram_location = base + 19'h03E00 + 19'(ad[8:0]);
          r.sram_store = 1'b1;
        end else if (we && (in_span(ad, 16'h4000, 16'h5FFF) || in_span(ad, 16'h8000, 16'h9FFF)))
        begin
          r.sram_location = base + 19'(ad[12:0]);
          r.sram_store = 1'b1;
        end else if (we && (in_span(ad, 16'h6000, 16'h7FFF) || in_span(ad, 16'hA000, 16'hBFFF)))
        begin
          r.sram_location = base + 19'h02000 + 19'(ad[12:0]);
          r.sram_store = 1'b1;
        end
        if (r.sram_store) r.sram_store_byte = a.write_byte;
      end
    end
    // claims follow the flags after this access
    g = model_flags[F_GAME];
    e = model_flags[F_EXROM];
    claim = model_flags[F_SRAMSEL] &&
            ((!g && !e && in_span(ad, 16'h8000, 16'hBFFF)) ||
             (g && !e && in_span(ad, 16'h8000, 16'h9FFF)) ||
             (!g && e && (in_span(ad, 16'h8000, 16'h9FFF) || in_span(ad, 16'hE000, 16'hFFFF))));
    r.rom_bank = model_bank;
    r.game_line = g;
    r.exrom_line = e;
    r.bus_driven = in_span(ad, 16'hDE00, 16'hDFFF) || claim;
    r.rom_claimed = claim;
    r.write_to_cart = model_flags[F_SRAMWE] && in_span(ad, 16'h4000, 16'hBFFF);
    return r;
  endfunction

  function automatic req_t mk(act_t act, logic [15:0] addr, logic [7:0] v);
    req_t a;
    a.action = act;
    a.bus_address = addr;
    a.write_byte = v;
    return a;
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0: return {8'hDE, 6'($urandom), 2'($urandom_range(2, 3))};
      1: return 16'hDE00 + 16'($urandom_range(0, 255));
      2: return 16'hDF00 + 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(16'h8000, 16'h9FFF));
      4: return 16'($urandom_range(16'hA000, 16'hBFFF));
      5: return 16'($urandom_range(16'hE000, 16'hFFFF));
      6: return 16'($urandom_range(16'h4000, 16'h7FFF));
      7: return ADDR_EDGES[$urandom_range(0, 17)];
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // keep_io: never let a control write set the i/o disable flag
  function automatic req_t random_access(bit keep_io);
    req_t a;
    a = mk($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, pick_address(), 8'($urandom));
    if (keep_io && a.action == ACT_WRITE && in_span(a.bus_address, 16'hDE00, 16'hDEFF) &&
        a.bus_address[1:0] == REG_CTRL)
      a.write_byte[F_IODIS + 2] = 1'b0;
    return a;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string field, logic [18:0] want, logic [18:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // sender: one transfer per accepted access, gaps between them
  always @(posedge clk) begin
    if (rst) begin
      access_ch.valid <= 1'b0;
      access_ch.data <= '0;
      send_gap <= 0;
      send_calm <= 1'b0;
    end else begin
      if (access_ch.valid && access_ch.ready)
        awaited_decodes.push_back(decode_access(access_ch.data));
      if (!access_ch.valid || access_ch.ready) begin
        if (send_gap != 0) begin
          access_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_accesses.size() != 0) begin
          access_ch.valid <= 1'b1;
          access_ch.data <= pending_accesses.pop_front();
          send_gap <= pick_gap(send_calm);
          if ($urandom_range(0, 47) == 0) send_calm <= !send_calm;
        end else begin
          access_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      decode_ch.ready <= 1'b0;
      stall_left <= 0;
      recv_calm <= 1'b0;
    end else begin
      if (decode_ch.valid && decode_ch.ready) begin
        if (awaited_decodes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, decode_ch.data);
          mismatch_count++;
        end else begin
          want = awaited_decodes.pop_front();
          check_field("register_data", 19'(want.register_data),
                      19'(decode_ch.data.register_data));
          check_field("data_source", 19'(want.data_source),
                      19'(decode_ch.data.data_source));
          check_field("sram_location", want.sram_location, decode_ch.data.sram_location);
          check_field("sram_store", 19'(want.sram_store), 19'(decode_ch.data.sram_store));
          check_field("sram_store_byte", 19'(want.sram_store_byte),
                      19'(decode_ch.data.sram_store_byte));
          check_field("rom_reload", 19'(want.rom_reload), 19'(decode_ch.data.rom_reload));
          check_field("rom_bank", 19'(want.rom_bank), 19'(decode_ch.data.rom_bank));
          check_field("game_line", 19'(want.game_line), 19'(decode_ch.data.game_line));
          check_field("exrom_line", 19'(want.exrom_line), 19'(decode_ch.data.exrom_line));
          check_field("bus_driven", 19'(want.bus_driven), 19'(decode_ch.data.bus_driven));
          check_field("rom_claimed", 19'(want.rom_claimed), 19'(decode_ch.data.rom_claimed));
          check_field("write_to_cart", 19'(want.write_to_cart),
                      19'(decode_ch.data.write_to_cart));
        end
      end
      if (stall_left != 0) begin
        decode_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        decode_ch.ready <= 1'b1;
        stall_left <= pick_gap(recv_calm);
        if ($urandom_range(0, 47) == 0) recv_calm <= !recv_calm;
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    #1;
    while (pending_accesses.size() != 0 || access_ch.valid || awaited_decodes.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int sent;
    access_ch.valid = 1'b0;
    access_ch.data = '0;
    decode_ch.ready = 1'b0;
    model_bank = '0;
    model_flags = '0;
    mismatch_count = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register reads at reset, masked bank write, offsets that fall through
    pending_accesses.push_back(mk(ACT_READ, 16'hDE02, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'hDE03, 8'hFF));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE02, 8'hFF));
    pending_accesses.push_back(mk(ACT_READ, 16'hDEFE, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'hF7));
    pending_accesses.push_back(mk(ACT_READ, 16'hDE07, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'h8000, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'hBFFF, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'hE000, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'hFFFF, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE00, 8'h5A));
    pending_accesses.push_back(mk(ACT_READ, 16'hDE01, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE02, 8'h2A));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'h10));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDF00, 8'hAA));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE01, 8'h11));
    pending_accesses.push_back(mk(ACT_WRITE, 16'h4000, 8'h55));
    pending_accesses.push_back(mk(ACT_WRITE, 16'h7FFF, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hBFFF, 8'hFF));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'h60));
    pending_accesses.push_back(mk(ACT_READ, 16'h9FFF, 8'h00));
    pending_accesses.push_back(mk(ACT_READ, 16'hA000, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'hA4));
    pending_accesses.push_back(mk(ACT_READ, 16'hE000, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hFFFF, 8'hFF));
    wait_drained();

    // mode setup followed by a burst of accesses in that mode
    sent = 0;
    while (sent < 450) begin
      pending_accesses.push_back(mk(ACT_WRITE, {8'hDE, 6'($urandom), REG_CTRL},
                                    8'($urandom) & ~(8'h01 << (F_IODIS + 2))));
      sent++;
      if ($urandom_range(0, 1)) begin
        pending_accesses.push_back(mk(ACT_WRITE, {8'hDE, 6'($urandom), REG_BANK}, 8'($urandom)));
        sent++;
      end
      repeat ($urandom_range(3, 12)) begin
        pending_accesses.push_back(random_access(1'b1));
        sent++;
      end
    end
    // hold the sender until every result is back
    wait_drained();

    // registers vanish once i/o is disabled, so this phase comes last
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'h18 | (8'($urandom) & 8'hC7)));
    pending_accesses.push_back(mk(ACT_READ, 16'hDE02, 8'h00));
    pending_accesses.push_back(mk(ACT_WRITE, 16'hDE03, 8'h5A));
    pending_accesses.push_back(mk(ACT_READ, 16'hDE03, 8'h00));
    repeat (60) pending_accesses.push_back(random_access(1'b0));
    wait_drained();
    repeat (5) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
